@@ hdl/cht_pkg.sv @@
`default_nettype none

package cht_pkg;

   // Table geometry.
   localparam int BUCKETS  = 1024;
   localparam int NODES    = 4096;
   localparam int KEY_BITS = 32;

   localparam int KEY_IN_W = 32;
   localparam int COUNT_W  = 16;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int NODE_W   = $clog2(NODES);
   localparam int POOL_W   = $clog2(NODES + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   typedef struct packed {
      logic                        command;
      logic signed [KEY_IN_W-1:0]  key;
   } cht_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               pool_full;
   } cht_rsp_type;

   // A bucket head: valid flag plus the index of the first node.
   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] idx;
   } cht_head_type;

   // One pool node: key, count and the link to the next node.
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [COUNT_W-1:0]  count;
      logic                next_valid;
      logic [NODE_W-1:0]   next_idx;
   } cht_node_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ONE,
      RES_FULL,
      RES_NODE
   } cht_res_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            clear_step;
      logic            accept;
      logic            follow_head;
      logic            follow_next;
      logic            alloc;
      logic            link_head;
      logic            link_tail;
      logic            bump;
      logic            load;
      cht_res_sel_type res_sel;
   } cht_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic head_valid;
      logic node_match;
      logic next_valid;
      logic pool_exh;
      logic out_free;
      logic is_query;
   } cht_status_type;

   // Reduce the incoming key to KEY_BITS bits, sign-extending where needed.
   function automatic logic [KEY_BITS-1:0] norm_key(input logic signed [KEY_IN_W-1:0] raw);
      logic signed [63:0] wide;
      wide = 64'(raw);
      return wide[KEY_BITS-1:0];
   endfunction

   // The non-negative remainder modulo BUCKETS of the sign-extended key.
   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_BITS-1:0] nk);
      logic signed [63:0] wide;
      wide = 64'($signed(nk));
      return wide[BUCKET_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/chained_hash_count_table.sv @@
`default_nettype none

// Counting hash table with separate chaining over a fixed pool of nodes.
// Each request item carries a command (insert or query) and a signed key; each
// produces exactly one response item with a count and a pool-full flag.
// Both channels use valid/ready; an item moves when valid and ready are high.
// After reset the block sweeps the bucket heads clear, one bucket per cycle;
// req_ready stays low until the sweep is done.
// A request is taken in only while idle. The bucket head is read first, then
// the nodes of its chain one by one, and the response is loaded when the key
// matches or the chain ends; appending a new node to a non-empty chain adds
// an append state after the walk. A miss on an empty bucket answers straight
// from the head read. The block takes one item at a time: no new request is
// taken until the response of the last one is loaded. One node memory read
// is made per chain node visited.
// The response sits in an output register: while the receiver stalls, the
// block finishes the walk and then waits. A freshly taken node may already be
// written, but the write that links it or bumps a count, and the response,
// wait until the register is free, so no item is lost or repeated.
module chained_hash_count_table
   import cht_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire cht_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output cht_rsp_type      rsp_payload
);

   cht_cmd_type    cmd;
   cht_status_type status;

   // The controller sequences the chain walk; the datapath holds the memories.
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cht_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

@@ hdl/cht_datapath.sv @@
`default_nettype none

module cht_datapath
   import cht_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cht_req_type    req_payload,
   input  wire logic           rsp_ready,
   output logic                rsp_valid,
   output cht_rsp_type         rsp_payload,
   input  wire cht_cmd_type    cmd,
   output cht_status_type      status
);

   // Bucket heads and the node pool, both with registered reads.
   cht_head_type head_mem [BUCKETS];
   cht_node_type node_mem [NODES];

   cht_head_type        head_rd_ff;
   cht_node_type        node_rd_ff;

   logic [BUCKET_W:0]   clr_cnt_ff, clr_cnt_in;
   logic [POOL_W-1:0]   pool_top_ff, pool_top_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cht_rsp_type         rsp_payload_ff, rsp_payload_in;

   logic                query_ff, query_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [BUCKET_W-1:0] bucket_ff, bucket_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [NODE_W-1:0]   new_idx_ff, new_idx_in;

   logic                head_we;
   logic [BUCKET_W-1:0] head_wa;
   cht_head_type        head_wd;
   logic                head_re;
   logic [BUCKET_W-1:0] head_ra;

   logic                node_we;
   logic [NODE_W-1:0]   node_wa;
   cht_node_type        node_wd;
   logic                node_re;
   logic [NODE_W-1:0]   node_ra;

   logic [KEY_BITS-1:0] req_key_norm;
   logic [COUNT_W-1:0]  count_upd;
   logic                out_free;

   assign req_key_norm = norm_key(req_payload.key);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign count_upd    = (query_ff || node_rd_ff.count == COUNT_MAX) ?
                         node_rd_ff.count : node_rd_ff.count + COUNT_ONE;

   always_comb begin
      head_we = cmd.clear_step || cmd.link_head;
      head_wa = cmd.clear_step ? clr_cnt_ff[BUCKET_W-1:0] : bucket_ff;
      head_wd = cmd.clear_step ? cht_head_type'('0) :
                cht_head_type'{valid: 1'b1, idx: pool_top_ff[NODE_W-1:0]};
      head_re = cmd.accept;
      head_ra = bucket_of(req_key_norm);

      node_re = cmd.follow_head || cmd.follow_next;
      node_ra = cmd.follow_head ? head_rd_ff.idx : node_rd_ff.next_idx;

      node_we = cmd.alloc || cmd.link_tail || (cmd.bump && !query_ff);
      node_wa = cur_ff;
      node_wd = node_rd_ff;
      if (cmd.alloc) begin
         node_wa = pool_top_ff[NODE_W-1:0];
         node_wd = cht_node_type'{key: key_ff, count: COUNT_ONE,
                                  next_valid: 1'b0, next_idx: '0};
      end else if (cmd.link_tail) begin
         node_wd.next_valid = 1'b1;
         node_wd.next_idx   = new_idx_ff;
      end else begin
         node_wd.count = count_upd;
      end
   end

   always_comb begin
      clr_cnt_in   = cmd.clear_step ? clr_cnt_ff + (BUCKET_W+1)'(1) : clr_cnt_ff;
      pool_top_in  = cmd.alloc ? pool_top_ff + POOL_W'(1) : pool_top_ff;
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);

      query_in   = cmd.accept ? req_payload.command : query_ff;
      key_in     = cmd.accept ? req_key_norm : key_ff;
      bucket_in  = cmd.accept ? head_ra : bucket_ff;
      cur_in     = node_re ? node_ra : cur_ff;
      new_idx_in = cmd.alloc ? pool_top_ff[NODE_W-1:0] : new_idx_ff;

      rsp_payload_in = rsp_payload_ff;
      if (cmd.load) begin
         case (cmd.res_sel)
            RES_ZERO: rsp_payload_in = cht_rsp_type'{count: '0, pool_full: 1'b0};
            RES_ONE:  rsp_payload_in = cht_rsp_type'{count: COUNT_ONE, pool_full: 1'b0};
            RES_FULL: rsp_payload_in = cht_rsp_type'{count: '0, pool_full: 1'b1};
            RES_NODE: rsp_payload_in = cht_rsp_type'{count: count_upd, pool_full: 1'b0};
            default:  rsp_payload_in = cht_rsp_type'{count: '0, pool_full: 1'b0};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         pool_top_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         pool_top_ff  <= pool_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      query_ff       <= query_in;
      key_ff         <= key_in;
      bucket_ff      <= bucket_in;
      cur_ff         <= cur_in;
      new_idx_ff     <= new_idx_in;
   end

   always_comb begin
      status.clear_done = clr_cnt_ff[BUCKET_W];
      status.head_valid = head_rd_ff.valid;
      status.node_match = (node_rd_ff.key == key_ff);
      status.next_valid = node_rd_ff.next_valid;
      status.pool_exh   = (pool_top_ff == POOL_W'(NODES));
      status.out_free   = out_free;
      status.is_query   = query_ff;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A node is taken from the pool only while one is left.
   a_alloc_not_exhausted: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (pool_top_ff < POOL_W'(NODES)))
      else $error("node allocated from an exhausted pool");

   // Each allocation moves the pool top on by exactly one.
   a_alloc_steps_pool: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |=> (pool_top_ff == $past(pool_top_ff) + POOL_W'(1)))
      else $error("pool top did not advance by one");

   // A new result never overwrites one still waiting to be taken.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   // No item is taken in before the bucket heads are cleared.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      !clr_cnt_ff[BUCKET_W] |-> !cmd.accept)
      else $error("item accepted during the clearing pass");

endmodule

`default_nettype wire

@@ hdl/cht_ctrl.sv @@
`default_nettype none

module cht_ctrl
   import cht_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire cht_status_type status,
   output cht_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE,
      ST_APPEND
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = RES_ZERO;

      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clear_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (status.head_valid) begin
               cmd.follow_head = 1'b1;
               state_in        = ST_NODE;
            end else if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
               if (status.is_query) begin
                  cmd.res_sel = RES_ZERO;
               end else if (status.pool_exh) begin
                  cmd.res_sel = RES_FULL;
               end else begin
                  cmd.alloc     = 1'b1;
                  cmd.link_head = 1'b1;
                  cmd.res_sel   = RES_ONE;
               end
            end
         end
         ST_NODE: begin
            if (status.node_match) begin
               if (status.out_free) begin
                  cmd.bump    = 1'b1;
                  cmd.load    = 1'b1;
                  cmd.res_sel = RES_NODE;
                  state_in    = ST_IDLE;
               end
            end else if (status.next_valid) begin
               cmd.follow_next = 1'b1;
            end else if (status.is_query || status.pool_exh) begin
               if (status.out_free) begin
                  cmd.load    = 1'b1;
                  cmd.res_sel = status.is_query ? RES_ZERO : RES_FULL;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.alloc = 1'b1;
               state_in  = ST_APPEND;
            end
         end
         ST_APPEND: begin
            if (status.out_free) begin
               cmd.link_tail = 1'b1;
               cmd.load      = 1'b1;
               cmd.res_sel   = RES_ONE;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire
